[rtl/avccrp_pkg.sv]
`default_nettype none

package avccrp_pkg;

  localparam int unsigned KindW = 4;

  localparam logic [KindW-1:0] PH_VERSION   = 4'd0;
  localparam logic [KindW-1:0] PH_PROFILE   = 4'd1;
  localparam logic [KindW-1:0] PH_COMPAT    = 4'd2;
  localparam logic [KindW-1:0] PH_LEVEL     = 4'd3;
  localparam logic [KindW-1:0] PH_LENSIZE   = 4'd4;
  localparam logic [KindW-1:0] PH_NSPS      = 4'd5;
  localparam logic [KindW-1:0] PH_SPSLEN_HI = 4'd6;
  localparam logic [KindW-1:0] PH_SPSLEN_LO = 4'd7;
  localparam logic [KindW-1:0] PH_SPS       = 4'd8;
  localparam logic [KindW-1:0] PH_NPPS      = 4'd9;
  localparam logic [KindW-1:0] PH_PPSLEN_HI = 4'd10;
  localparam logic [KindW-1:0] PH_PPSLEN_LO = 4'd11;
  localparam logic [KindW-1:0] PH_PPS       = 4'd12;
  localparam logic [KindW-1:0] PH_TRAILING  = 4'd13;

  localparam logic [7:0] LenSizeMask = 8'h03;
  localparam logic [7:0] NspsMask    = 8'h1F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       record_start;
  } in_word_t;

  typedef struct packed {
    logic [KindW-1:0] field_kind;
    logic [7:0]       field_value;
    logic [7:0]       unit_index;
    logic [15:0]      unit_offset;
    logic             unit_end;
    logic             record_complete;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/avccrp_stream_if.sv]
`default_nettype none

interface avccrp_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/avc_config_record_parser_unit.sv]
// AVC decoder configuration record parser. Takes one record byte per word
// and returns one tagged word per byte: field kind, masked value and, for
// parameter-set payload bytes, set index, byte offset and end-of-set mark,
// plus a record-complete mark. The field decode and the counter updates
// sit between the parse state registers and the result register, so a
// byte is accepted every cycle while the result register is empty or
// being drained, and its tagged word is registered. A record start
// flag on a byte restarts parsing with that byte as the version byte.
`default_nettype none

module avc_config_record_parser_unit
  import avccrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  avccrp_stream_if.sink   in_i,
  avccrp_stream_if.source out_o
);

  logic [KindW-1:0] phase_q, phase_d;
  logic [7:0]       sets_q, sets_d;
  logic [15:0]      rem_q, rem_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [7:0]       set_num_q, set_num_d;
  logic [15:0]      pos_q, pos_d;
  out_word_t        out_q, out_d;
  logic             out_valid_q;

  in_word_t         in_word;
  logic             accept;
  logic [KindW-1:0] phase_c;
  logic [7:0]       sets_c, set_num_c, len_hi_c, sets_dec, value;
  logic [15:0]      rem_c, pos_c, rem_dec, len;
  logic             is_pps;

  assign in_word   = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign phase_c   = in_word.record_start ? PH_VERSION : phase_q;
  assign sets_c    = in_word.record_start ? 8'd0 : sets_q;
  assign rem_c     = in_word.record_start ? 16'd0 : rem_q;
  assign len_hi_c  = in_word.record_start ? 8'd0 : len_hi_q;
  assign set_num_c = in_word.record_start ? 8'd0 : set_num_q;
  assign pos_c     = in_word.record_start ? 16'd0 : pos_q;
  assign sets_dec  = sets_c - 8'd1;
  assign rem_dec   = rem_c - 16'd1;
  assign len       = {len_hi_c, in_word.in_byte};
  assign is_pps    = phase_c inside {PH_PPSLEN_LO, PH_PPS};

  always_comb begin
    phase_d   = phase_c;
    sets_d    = sets_c;
    rem_d     = rem_c;
    len_hi_d  = len_hi_c;
    set_num_d = set_num_c;
    pos_d     = pos_c;
    value     = in_word.in_byte;
    out_d     = '0;
    out_d.field_kind = phase_c;
    case (phase_c)
      PH_VERSION, PH_PROFILE, PH_COMPAT, PH_LEVEL: begin
        phase_d = phase_c + 4'd1;
      end
      PH_LENSIZE: begin
        value   = in_word.in_byte & LenSizeMask;
        phase_d = PH_NSPS;
      end
      PH_NSPS, PH_NPPS: begin
        if (phase_c == PH_NSPS) begin
          value = in_word.in_byte & NspsMask;
        end
        sets_d    = value;
        set_num_d = 8'd0;
        if (value != 8'd0) begin
          phase_d = (phase_c == PH_NSPS) ? PH_SPSLEN_HI : PH_PPSLEN_HI;
        end else if (phase_c == PH_NSPS) begin
          phase_d = PH_NPPS;
        end else begin
          phase_d = PH_TRAILING;
          out_d.record_complete = 1'b1;
        end
      end
      PH_SPSLEN_HI, PH_PPSLEN_HI: begin
        len_hi_d = in_word.in_byte;
        phase_d  = phase_c + 4'd1;
      end
      PH_SPSLEN_LO, PH_PPSLEN_LO, PH_SPS, PH_PPS: begin
        if (phase_c inside {PH_SPS, PH_PPS}) begin
          out_d.unit_index  = set_num_c;
          out_d.unit_offset = pos_c;
          pos_d = pos_c + 16'd1;
          rem_d = rem_dec;
        end else if (len != 16'd0) begin
          rem_d   = len;
          pos_d   = 16'd0;
          phase_d = phase_c + 4'd1;
        end
        if (((phase_c inside {PH_SPS, PH_PPS}) && rem_dec == 16'd0) ||
            ((phase_c inside {PH_SPSLEN_LO, PH_PPSLEN_LO}) && len == 16'd0)) begin
          out_d.unit_end = (phase_c inside {PH_SPS, PH_PPS});
          sets_d    = sets_dec;
          set_num_d = set_num_c + 8'd1;
          if (sets_dec != 8'd0) begin
            phase_d = is_pps ? PH_PPSLEN_HI : PH_SPSLEN_HI;
          end else if (is_pps) begin
            phase_d = PH_TRAILING;
            out_d.record_complete = 1'b1;
          end else begin
            phase_d = PH_NPPS;
          end
        end
      end
      default: begin
        out_d.field_kind = PH_TRAILING;
        phase_d = PH_TRAILING;
      end
    endcase
    out_d.field_value = value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_VERSION;
      sets_q      <= '0;
      rem_q       <= '0;
      len_hi_q    <= '0;
      set_num_q   <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        sets_q    <= sets_d;
        rem_q     <= rem_d;
        len_hi_q  <= len_hi_d;
        set_num_q <= set_num_d;
        pos_q     <= pos_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire
